@@ rtl/pabv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabv_pkg
// Shared types for the pseudo angle pipeline: quadrant codes and the
// per-vector side information that rides along the normalize lanes.
// ----------------------------------------------------------------------------
package pabv_pkg;

   typedef enum logic [1:0] {
      QUAD_FIRST,    // dx > 0, dy > 0: sine
      QUAD_LEFT,     // dx <= 0: 2 - sine
      QUAD_FOURTH    // dx > 0, dy <= 0: 3 + cosine
   } quad_type;

   typedef struct packed {
      logic     dy_neg;
      quad_type quad;
   } vec_info_type;

endpackage

@@ rtl/pabv_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pabv_norm
// One normalize lane: squares, restoring divide c^2 * 2^(2F) / len2 one
// quotient bit per stage, then integer square root one bit per stage.
// ----------------------------------------------------------------------------
module pabv_norm #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16,
   parameter int TAG_W      = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ce,
   input  logic [TAG_W-1:0]        in_tag,
   input  logic [COORD_BITS:0]     in_ax,
   input  logic [COORD_BITS:0]     in_ay,
   input  logic                    in_use_x,
   output logic [TAG_W-1:0]        out_tag,
   output logic [FRAC_BITS:0]      out_mag
);

   localparam int L  = 2 * COORD_BITS + 2;
   localparam int Q  = 2 * FRAC_BITS + 1;
   localparam int RW = FRAC_BITS + 1;
   localparam int SW = 2 * FRAC_BITS + 3;
   localparam int NS = FRAC_BITS + 1;

   // squares
   logic [L-1:0]     sqx_ff, sqy_ff;
   logic             usex_ff;
   logic [TAG_W-1:0] taga_ff;
   // length and dividend
   logic [L-1:0]     lenb_ff, remb_ff;
   logic [TAG_W-1:0] tagb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         taga_ff <= '0;
         tagb_ff <= '0;
      end else if (ce) begin
         taga_ff <= in_tag;
         sqx_ff  <= L'(in_ax) * L'(in_ax);
         sqy_ff  <= L'(in_ay) * L'(in_ay);
         usex_ff <= in_use_x;
         tagb_ff <= taga_ff;
         lenb_ff <= sqx_ff + sqy_ff;
         remb_ff <= usex_ff ? sqx_ff : sqy_ff;
      end
   end

   logic [L-1:0]     drem_ff [Q];
   logic [L-1:0]     dlen_ff [Q];
   logic [Q-1:0]     dq_ff   [Q];
   logic [TAG_W-1:0] dtag_ff [Q];

   for (genvar k = 0; k < Q; k++) begin : gen_div
      logic [L-1:0]     prem, plen;
      logic [Q-1:0]     pq;
      logic [TAG_W-1:0] ptag;
      logic [L:0]       r, nrem;
      logic             ge;
      if (k == 0) begin : gen_first
         assign prem = remb_ff;
         assign plen = lenb_ff;
         assign pq   = '0;
         assign ptag = tagb_ff;
         assign r    = {1'b0, prem};
      end else begin : gen_next
         assign prem = drem_ff[k-1];
         assign plen = dlen_ff[k-1];
         assign pq   = dq_ff[k-1];
         assign ptag = dtag_ff[k-1];
         assign r    = {prem, 1'b0};
      end
      assign ge   = r >= {1'b0, plen};
      assign nrem = ge ? r - {1'b0, plen} : r;

      always_ff @(posedge clock) begin
         if (reset) begin
            dtag_ff[k] <= '0;
         end else if (ce) begin
            dtag_ff[k] <= ptag;
            drem_ff[k] <= nrem[L-1:0];
            dlen_ff[k] <= plen;
            dq_ff[k]   <= {pq[Q-2:0], ge};
         end
      end
   end

   logic [Q-1:0]     sq_q_ff [NS];
   logic [RW-1:0]    sres_ff [NS];
   logic [SW-1:0]    ssq_ff  [NS];
   logic [TAG_W-1:0] stag_ff [NS];

   // root bit FRAC_BITS - j; keep res^2 so a trial needs only adds
   for (genvar j = 0; j < NS; j++) begin : gen_sqrt
      localparam int B = FRAC_BITS - j;
      logic [Q-1:0]     pq;
      logic [RW-1:0]    pres;
      logic [SW-1:0]    psq, t2;
      logic [TAG_W-1:0] ptag;
      logic             ok;
      if (j == 0) begin : gen_first
         assign pq   = dq_ff[Q-1];
         assign pres = '0;
         assign psq  = '0;
         assign ptag = dtag_ff[Q-1];
      end else begin : gen_next
         assign pq   = sq_q_ff[j-1];
         assign pres = sres_ff[j-1];
         assign psq  = ssq_ff[j-1];
         assign ptag = stag_ff[j-1];
      end
      assign t2 = psq + (SW'(pres) << (B + 1)) + (SW'(1) << (2 * B));
      assign ok = t2 <= SW'(pq);

      always_ff @(posedge clock) begin
         if (reset) begin
            stag_ff[j] <= '0;
         end else if (ce) begin
            stag_ff[j] <= ptag;
            sq_q_ff[j] <= pq;
            sres_ff[j] <= ok ? (pres | (RW'(1) << B)) : pres;
            ssq_ff[j]  <= ok ? t2 : psq;
         end
      end
   end

   assign out_tag = stag_ff[NS-1];
   assign out_mag = sres_ff[NS-1];

endmodule

@@ rtl/pseudo_angle_between_vectors.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseudo_angle_between_vectors
// Pseudo angle in (0,4] from a base point to two other points.
// ----------------------------------------------------------------------------
// One point triple is taken per clock while the skid word is empty, and one
// word comes out per triple, in order. The normalize lanes spend one stage
// per quotient bit of the divide and one per bit of the square root. The
// output register plus a one-word skid stage let the input keep flowing when
// the result side stalls, until the skid word is filled. degenerate marks a
// point equal to the base; pseudo_angle is zero then.
module pseudo_angle_between_vectors #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // base_x, base_y, from_x, from_y, to_x, to_y (lowest first)
   input  logic [((6*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pseudo_angle, degenerate (lowest first)
   output logic [((FRAC_BITS+4+7)/8)*8-1:0]  rsp_tdata
);

   localparam int C   = COORD_BITS;
   localparam int OW  = FRAC_BITS + 3;
   localparam int ODW = ((FRAC_BITS + 4 + 7) / 8) * 8;
   localparam int TA  = 2 + $bits(pabv_pkg::vec_info_type);
   localparam int TB  = $bits(pabv_pkg::vec_info_type);
   localparam logic [OW-1:0] UNIT       = OW'(1) << FRAC_BITS;
   localparam logic [OW-1:0] TWO_UNIT   = UNIT << 1;
   localparam logic [OW-1:0] THREE_UNIT = TWO_UNIT + UNIT;
   localparam logic [OW-1:0] FOUR_UNIT  = UNIT << 2;

   logic             ce;
   logic             s0_v_ff;
   logic signed [C:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff;

   logic [C-1:0] bx, by, fx, fy, tx, ty;
   assign bx = req_tdata[0*C +: C];
   assign by = req_tdata[1*C +: C];
   assign fx = req_tdata[2*C +: C];
   assign fy = req_tdata[3*C +: C];
   assign tx = req_tdata[4*C +: C];
   assign ty = req_tdata[5*C +: C];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (ce) begin
         s0_v_ff <= req_tvalid;
         dx1_ff  <= $signed({fx[C-1], fx}) - $signed({bx[C-1], bx});
         dy1_ff  <= $signed({by[C-1], by}) - $signed({fy[C-1], fy});
         dx2_ff  <= $signed({tx[C-1], tx}) - $signed({bx[C-1], bx});
         dy2_ff  <= $signed({by[C-1], by}) - $signed({ty[C-1], ty});
      end
   end

   // magnitudes and quadrant of each vector
   logic [C:0] ax1, ay1, ax2, ay2;
   pabv_pkg::vec_info_type info1, info2;
   logic zero1, zero2;

   always_comb begin
      ax1 = dx1_ff[C] ? (C+1)'(-dx1_ff) : dx1_ff;
      ay1 = dy1_ff[C] ? (C+1)'(-dy1_ff) : dy1_ff;
      ax2 = dx2_ff[C] ? (C+1)'(-dx2_ff) : dx2_ff;
      ay2 = dy2_ff[C] ? (C+1)'(-dy2_ff) : dy2_ff;
      zero1 = (dx1_ff == '0) && (dy1_ff == '0);
      zero2 = (dx2_ff == '0) && (dy2_ff == '0);
      info1.dy_neg = dy1_ff[C];
      info2.dy_neg = dy2_ff[C];
      if (dx1_ff[C] || dx1_ff == '0) begin
         info1.quad = pabv_pkg::QUAD_LEFT;
      end else if (!dy1_ff[C] && dy1_ff != '0) begin
         info1.quad = pabv_pkg::QUAD_FIRST;
      end else begin
         info1.quad = pabv_pkg::QUAD_FOURTH;
      end
      if (dx2_ff[C] || dx2_ff == '0) begin
         info2.quad = pabv_pkg::QUAD_LEFT;
      end else if (!dy2_ff[C] && dy2_ff != '0) begin
         info2.quad = pabv_pkg::QUAD_FIRST;
      end else begin
         info2.quad = pabv_pkg::QUAD_FOURTH;
      end
   end

   logic [TA-1:0]        taga;
   logic [TB-1:0]        tagb;
   logic [FRAC_BITS:0]   mag1, mag2;

   pabv_norm #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .TAG_W(TA)) u_norm1 (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_tag   ({s0_v_ff, zero1 | zero2, info1}),
      .in_ax    (ax1),
      .in_ay    (ay1),
      .in_use_x (info1.quad == pabv_pkg::QUAD_FOURTH),
      .out_tag  (taga),
      .out_mag  (mag1)
   );

   pabv_norm #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .TAG_W(TB)) u_norm2 (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_tag   (info2),
      .in_ax    (ax2),
      .in_ay    (ay2),
      .in_use_x (info2.quad == pabv_pkg::QUAD_FOURTH),
      .out_tag  (tagb),
      .out_mag  (mag2)
   );

   function automatic logic [OW-1:0] pseudo_of(input pabv_pkg::vec_info_type vi,
                                               input logic [FRAC_BITS:0] m);
      logic [OW-1:0] mw;
      mw = OW'(m);
      case (vi.quad)
         pabv_pkg::QUAD_FIRST:  pseudo_of = mw;
         pabv_pkg::QUAD_LEFT:   pseudo_of = vi.dy_neg ? TWO_UNIT + mw : TWO_UNIT - mw;
         pabv_pkg::QUAD_FOURTH: pseudo_of = THREE_UNIT + mw;
         default:               pseudo_of = '0;
      endcase
   endfunction

   pabv_pkg::vec_info_type vi1, vi2;
   logic                   inc_v, inc_deg;
   logic [OW-1:0]          p1, p2, inc_angle;
   logic signed [OW:0]     diff;

   always_comb begin
      vi1   = pabv_pkg::vec_info_type'(taga[TB-1:0]);
      vi2   = pabv_pkg::vec_info_type'(tagb);
      inc_v = taga[TA-1];
      inc_deg = taga[TA-2];
      p1 = pseudo_of(vi1, mag1);
      p2 = pseudo_of(vi2, mag2);
      diff = $signed({1'b0, p2}) - $signed({1'b0, p1});
      if (diff <= 0) begin
         diff = diff + $signed({1'b0, FOUR_UNIT});
      end
      inc_angle = inc_deg ? '0 : diff[OW-1:0];
   end

   // output register with one skid word behind it
   logic          out_v_ff, skid_v_ff, out_deg_ff, skid_deg_ff;
   logic [OW-1:0] out_angle_ff, skid_angle_ff;
   logic          out_load;

   assign ce         = !skid_v_ff;
   assign req_tready = ce;
   assign out_load   = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_load) begin
         if (skid_v_ff) begin
            out_v_ff     <= 1'b1;
            out_angle_ff <= skid_angle_ff;
            out_deg_ff   <= skid_deg_ff;
            skid_v_ff    <= 1'b0;
         end else begin
            out_v_ff     <= inc_v;
            out_angle_ff <= inc_angle;
            out_deg_ff   <= inc_deg;
         end
      end else if (ce && inc_v) begin
         // hold the word that arrives while the output stalls
         skid_v_ff     <= 1'b1;
         skid_angle_ff <= inc_angle;
         skid_deg_ff   <= inc_deg;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = ODW'({out_deg_ff, out_angle_ff});

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid word held without an output word");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_deg_ff) |-> (out_angle_ff == '0))
      else $error("degenerate word with nonzero angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_deg_ff) |-> (out_angle_ff != '0 && out_angle_ff <= FOUR_UNIT))
      else $error("angle outside (0,4]");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_tready) |=> !skid_v_ff)
      else $error("skid word not drained");
`endif

endmodule

@@ tb/pseudo_angle_between_vectors_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseudo_angle_between_vectors_tb
// Streams point triples into the pseudo angle block and checks each result
// word against a predictor built on exact integer square root and division.
// Two phases idle at random; the full-rate third has one long receiver stall.
// ----------------------------------------------------------------------------
module pseudo_angle_between_vectors_tb;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int REQ_W = ((6*COORD_BITS+7)/8)*8;
   localparam int RSP_W = ((FRAC_BITS+4+7)/8)*8;
   localparam int ANG_W = FRAC_BITS + 3;
   localparam int LATENCY = 3*FRAC_BITS + 5 + 4;
   localparam int RANDOM_ITEMS = 1530;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [ANG_W-1:0] pseudo_angle;
      logic             degenerate;
   } angle_result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // base_x, base_y, from_x, from_y, to_x, to_y
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // pseudo_angle, degenerate

   logic [REQ_W-1:0] triple_queue[$];
   angle_result_type expected_angles[$];
   int               send_idle_pct;
   int               recv_idle_pct;
   int               hold_cycles;
   int               error_count;
   int               words_checked;
   int               degenerate_seen;
   longint           cycle_count = 0;

   pseudo_angle_between_vectors #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic longint unsigned isqrt(longint unsigned r);
      longint unsigned res;
      longint unsigned t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         t = res | (64'd1 << b);
         if (t * t <= r) res = t;
      end
      return res;
   endfunction

   // floor(c * 2^F / sqrt(len2)) = isqrt(floor(c^2 * 2^2F / len2))
   function automatic longint unsigned unit_component(longint unsigned c,
                                                      longint unsigned len2);
      logic [127:0] num;
      num = (128'(c) * 128'(c)) << (2*FRAC_BITS);
      return isqrt(64'(num / 128'(len2)));
   endfunction

   function automatic longint vector_pseudo(longint dx, longint dy);
      longint unsigned ax, ay, len2;
      longint s;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      len2 = ax*ax + ay*ay;
      if (dx > 0 && dy > 0) return longint'(unit_component(ay, len2));
      if (dx <= 0) begin
         s = longint'(unit_component(ay, len2));
         if (dy < 0) s = -s;
         return 2*(64'sd1 <<< FRAC_BITS) - s;
      end
      return 3*(64'sd1 <<< FRAC_BITS) + longint'(unit_component(ax, len2));
   endfunction

   function automatic angle_result_type predict_angle(logic [REQ_W-1:0] w);
      angle_result_type r;
      longint bx, by, fx, fy, tx, ty, dx1, dy1, dx2, dy2, diff;
      bx = longint'($signed(w[0*COORD_BITS +: COORD_BITS]));
      by = longint'($signed(w[1*COORD_BITS +: COORD_BITS]));
      fx = longint'($signed(w[2*COORD_BITS +: COORD_BITS]));
      fy = longint'($signed(w[3*COORD_BITS +: COORD_BITS]));
      tx = longint'($signed(w[4*COORD_BITS +: COORD_BITS]));
      ty = longint'($signed(w[5*COORD_BITS +: COORD_BITS]));
      dx1 = fx - bx; dy1 = by - fy;
      dx2 = tx - bx; dy2 = by - ty;
      if ((dx1 == 0 && dy1 == 0) || (dx2 == 0 && dy2 == 0)) begin
         r.pseudo_angle = '0;
         r.degenerate = 1'b1;
         return r;
      end
      diff = vector_pseudo(dx2, dy2) - vector_pseudo(dx1, dy1);
      if (diff <= 0) diff += 4*(64'sd1 <<< FRAC_BITS);
      r.pseudo_angle = diff[ANG_W-1:0];
      r.degenerate = 1'b0;
      return r;
   endfunction

   function automatic logic [REQ_W-1:0] pack_triple(int bx, int by, int fx, int fy,
                                                     int tx, int ty);
      logic [REQ_W-1:0] w;
      w = '0;
      w[0*COORD_BITS +: COORD_BITS] = bx[COORD_BITS-1:0];
      w[1*COORD_BITS +: COORD_BITS] = by[COORD_BITS-1:0];
      w[2*COORD_BITS +: COORD_BITS] = fx[COORD_BITS-1:0];
      w[3*COORD_BITS +: COORD_BITS] = fy[COORD_BITS-1:0];
      w[4*COORD_BITS +: COORD_BITS] = tx[COORD_BITS-1:0];
      w[5*COORD_BITS +: COORD_BITS] = ty[COORD_BITS-1:0];
      return w;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                        : -32768 + $urandom_range(0, 3);
         default: return $urandom_range(0, 200) - 100;
      endcase
   endfunction

   // driver: hold the word until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_angles.push_back(predict_angle(req_tdata));
         if (triple_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= triple_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready, with a long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      angle_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_angles.size() == 0) begin
            $error("result word with no expectation waiting: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_r = expected_angles.pop_front();
            words_checked++;
            if (exp_r.degenerate) degenerate_seen++;
            if (rsp_tdata[ANG_W-1:0] !== exp_r.pseudo_angle) begin
               $error("pseudo_angle expected %0d actual %0d",
                      exp_r.pseudo_angle, rsp_tdata[ANG_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[ANG_W] !== exp_r.degenerate) begin
               $error("degenerate expected %0d actual %0d",
                      exp_r.degenerate, rsp_tdata[ANG_W]);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic wait_drained();
      while (triple_queue.size() > 0 || req_tvalid || expected_angles.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int bx, by, r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      send_idle_pct = 15;
      recv_idle_pct = 71;
      hold_cycles = 0;
      error_count = 0;
      words_checked = 0;
      degenerate_seen = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each quadrant, axes, coincident points
      triple_queue.push_back(pack_triple(0, 0, 0, 0, 5, 5));
      triple_queue.push_back(pack_triple(0, 0, 5, 5, 0, 0));
      triple_queue.push_back(pack_triple(7, -3, 7, -3, 7, -3));
      triple_queue.push_back(pack_triple(0, 0, 10, -10, 10, -10));
      triple_queue.push_back(pack_triple(0, 0, 10, 0, 0, -10));
      triple_queue.push_back(pack_triple(0, 0, 0, -10, -10, 0));
      triple_queue.push_back(pack_triple(0, 0, -10, 0, 0, 10));
      triple_queue.push_back(pack_triple(0, 0, 0, 10, 10, 0));
      triple_queue.push_back(pack_triple(0, 0, 3, -4, -3, 4));
      triple_queue.push_back(pack_triple(0, 0, -3, -4, 3, 4));
      triple_queue.push_back(pack_triple(-32768, -32768, 32767, 32767, 32767, -32768));
      triple_queue.push_back(pack_triple(32767, 32767, -32768, -32768, -32768, 32767));
      triple_queue.push_back(pack_triple(-32768, 32767, 32767, -32768, -32768, -32768));
      triple_queue.push_back(pack_triple(32767, -32768, -32768, 32767, 32767, 32767));
      triple_queue.push_back(pack_triple(0, 0, 1, 0, 32767, -1));
      triple_queue.push_back(pack_triple(0, 0, -1, 0, -32768, 1));
      triple_queue.push_back(pack_triple(100, 100, 101, 99, 99, 101));
      triple_queue.push_back(pack_triple(-1, -1, -1, 0, 0, -1));
      triple_queue.push_back(pack_triple(0, 0, 1, -1, 1, -2));
      triple_queue.push_back(pack_triple(0, 0, 1, -2, 1, -1));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS/3) begin
            wait_drained();
            send_idle_pct = 71;
            recv_idle_pct = 15;
         end else if (i == 2*RANDOM_ITEMS/3) begin
            wait_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_cycles = 300;
         end
         bx = rand_coord();
         by = rand_coord();
         r = $urandom_range(0, 19);
         if (r == 0)
            triple_queue.push_back(pack_triple(bx, by, bx, by, rand_coord(), rand_coord()));
         else if (r == 1)
            triple_queue.push_back(pack_triple(bx, by, rand_coord(), rand_coord(), bx, by));
         else if (r == 2)
            triple_queue.push_back(pack_triple(bx, by, bx + $urandom_range(0, 2) - 1,
                                               rand_coord(), rand_coord(),
                                               by + $urandom_range(0, 2) - 1));
         else
            triple_queue.push_back(pack_triple(bx, by, rand_coord(), rand_coord(),
                                               rand_coord(), rand_coord()));
         if (triple_queue.size() > 64) @(posedge clock);
      end
      wait_drained();
      repeat (LATENCY) @(posedge clock);

      $display("%0d result words checked, %0d of them degenerate, across three idle mixes",
               words_checked, degenerate_seen);
      $display("with a 300-cycle receiver stall during full-rate input");
      if (error_count == 0 && expected_angles.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
